// ----- hdl/rgbled_pkg.sv -----
package rgbled_pkg;

  // chain size default and its legal range
  localparam int unsigned LED_COUNT_DEF = 12;
  localparam int unsigned LED_COUNT_MAX = 16;

  // field widths
  localparam int unsigned TICK_W   = 10;
  localparam int unsigned LATCH_W  = 16;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // one LED row holds green, red, blue, sent from the top bit down
  localparam int unsigned ROW_W     = 3 * COLOR_W;
  localparam int unsigned BIT_SEL_W = $clog2(ROW_W);
  localparam logic [BIT_SEL_W-1:0] BIT_SEL_FIRST = BIT_SEL_W'(ROW_W - 1);

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  // register reset values
  localparam logic [TICK_W-1:0]  ZERO_HIGH_RST  = TICK_W'(30);
  localparam logic [TICK_W-1:0]  ONE_HIGH_RST   = TICK_W'(60);
  localparam logic [TICK_W-1:0]  BIT_PERIOD_RST = TICK_W'(125);
  localparam logic [LATCH_W-1:0] LATCH_RST      = LATCH_W'(8000);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH  = 2'd0,
    CFG_ONE_HIGH   = 2'd1,
    CFG_BIT_PERIOD = 2'd2,
    CFG_LATCH      = 2'd3
  } cfg_idx_e;

  // item kinds carried in tuser
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

endpackage

// ----- hdl/addressable_rgb_led_chain_driver.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/tready_o       tuser: opcode; tdata: index, red, green, blue
// m_axis    out  m_axis_tvalid_o/tready_i       tdata: data_line, busy_res
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// one beat per cycle sustained while results are taken; each beat is registered
// at the input, then processed in one pass of the wire-timing logic into the
// result register, from which its result is offered.
// a stalled result stalls processing; an empty input register still takes
// one beat while the result waits. cfg writes are always taken.
// rst_ni clears the valid flags, wire state and frame store; cfg registers get reset values.
module addressable_rgb_led_chain_driver
  import rgbled_pkg::*;
#(
  parameter int unsigned LED_COUNT = LED_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // beat in
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [3:0] led_index, [11:4] red, [19:12] green, [27:20] blue, [31:28] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] opcode
  input  logic                   s_axis_tuser_i,
  // beat out
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] data_line, [1] busy_res, [7:2] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int unsigned LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);

  // config registers
  logic [TICK_W-1:0]  zero_high_q, one_high_q, period_q;
  logic [LATCH_W-1:0] latch_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q   <= ZERO_HIGH_RST;
      one_high_q    <= ONE_HIGH_RST;
      period_q      <= BIT_PERIOD_RST;
      latch_ticks_q <= LATCH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ZERO_HIGH:  zero_high_q   <= cfg_data_i[TICK_W-1:0];
        CFG_ONE_HIGH:   one_high_q    <= cfg_data_i[TICK_W-1:0];
        CFG_BIT_PERIOD: period_q      <= cfg_data_i[TICK_W-1:0];
        CFG_LATCH:      latch_ticks_q <= cfg_data_i[LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_valid_q;
  op_e                op_q;
  logic [INDEX_W-1:0] index_q;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;
  logic               advance;
  logic               out_valid_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      op_q    <= op_e'(s_axis_tuser_i);
      index_q <= s_axis_tdata_i[INDEX_W-1:0];
      red_q   <= s_axis_tdata_i[INDEX_W +: COLOR_W];
      green_q <= s_axis_tdata_i[INDEX_W+COLOR_W +: COLOR_W];
      blue_q  <= s_axis_tdata_i[INDEX_W+2*COLOR_W +: COLOR_W];
    end
  end

  // wire state
  logic [ROW_W-1:0]     store_q [LED_COUNT];
  logic [LED_W-1:0]     led_q, led_d;
  logic [BIT_SEL_W-1:0] bit_sel_q, bit_sel_d;
  logic [TICK_W-1:0]    cnt_q, cnt_d;
  logic [LATCH_W-1:0]   latch_q, latch_d;
  logic                 sending_q, sending_d;
  logic                 pending_q, pending_d;
  logic                 line_q, line_d;
  logic                 busy_q, busy_d;
  logic                 store_we;

  // scratch for the tick
  logic                 start;
  logic                 snd;
  logic [LED_W-1:0]     led_cur;
  logic [BIT_SEL_W-1:0] bit_cur;
  logic [TICK_W-1:0]    cnt_cur;
  logic [TICK_W:0]      cnt_inc;
  logic                 bit_val;
  logic [TICK_W-1:0]    high;
  logic                 cell_end;

  // one pass of the model step
  always_comb begin
    led_d     = led_q;
    bit_sel_d = bit_sel_q;
    cnt_d     = cnt_q;
    latch_d   = latch_q;
    sending_d = sending_q;
    pending_d = pending_q;
    line_d    = line_q;
    store_we  = 1'b0;

    start    = !sending_q && (latch_q == '0) && pending_q;
    snd      = sending_q || start;
    led_cur  = start ? '0 : led_q;
    bit_cur  = start ? BIT_SEL_FIRST : bit_sel_q;
    cnt_cur  = start ? '0 : cnt_q;
    bit_val  = store_q[led_cur][bit_cur];
    high     = bit_val ? one_high_q : zero_high_q;
    cnt_inc  = {1'b0, cnt_cur} + 1'b1;
    cell_end = cnt_inc[TICK_W] || (cnt_inc[TICK_W-1:0] >= period_q);

    if (op_q == OP_SET) begin
      store_we  = ({1'b0, index_q} < (INDEX_W+1)'(LED_COUNT));
      pending_d = 1'b1;
    end else begin
      if (start) pending_d = 1'b0;
      if (snd) begin
        line_d    = (cnt_cur < high);
        sending_d = 1'b1;
        led_d     = led_cur;
        bit_sel_d = bit_cur;
        cnt_d     = cnt_inc[TICK_W-1:0];
        if (cell_end) begin
          cnt_d = '0;
          if (bit_cur == '0) begin
            bit_sel_d = BIT_SEL_FIRST;
            if (led_cur == LED_LAST) begin
              led_d     = '0;
              sending_d = 1'b0;
              latch_d   = latch_ticks_q;
            end else begin
              led_d = led_cur + 1'b1;
            end
          end else begin
            bit_sel_d = bit_cur - 1'b1;
          end
        end
      end else begin
        line_d = 1'b0;
        if (latch_q != '0) latch_d = latch_q - 1'b1;
      end
    end

    busy_d = sending_d || (latch_d != '0);
  end

  // state and frame store update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q     <= '0;
      bit_sel_q <= BIT_SEL_FIRST;
      cnt_q     <= '0;
      latch_q   <= '0;
      sending_q <= 1'b0;
      pending_q <= 1'b0;
      line_q    <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) store_q[i] <= '0;
    end else if (advance) begin
      led_q     <= led_d;
      bit_sel_q <= bit_sel_d;
      cnt_q     <= cnt_d;
      latch_q   <= latch_d;
      sending_q <= sending_d;
      pending_q <= pending_d;
      line_q    <= line_d;
      if (store_we) store_q[index_q[LED_W-1:0]] <= {green_q, red_q, blue_q};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) busy_q <= busy_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-2){1'b0}}, busy_q, line_q};

endmodule
